// File: sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared types, command codes and sizing constants of the page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned PageCount = 4096;
  localparam int unsigned WordBits  = 64;
  localparam int unsigned WordCount = PageCount / WordBits;

  typedef logic [12:0] page_t;
  typedef logic [5:0]  word_idx_t;
  typedef logic [63:0] map_word_t;
  typedef logic [15:0] ref_t;

  localparam page_t HintReset     = 13'd256;
  localparam page_t ReservedReset = 13'd256;
  localparam page_t PageLimit     = 13'd4096;
  localparam page_t CountMax      = 13'h1fff;
  localparam ref_t  RefMax        = 16'hffff;

  typedef enum logic [2:0] {
    CMD_ALLOC      = 3'd0,
    CMD_ALLOC_RUN  = 3'd1,
    CMD_FREE       = 3'd2,
    CMD_SHARE      = 3'd3,
    CMD_QUERY      = 3'd4,
    CMD_MARK_FREE  = 3'd5,
    CMD_MARK_USED  = 3'd6,
    CMD_NONE       = 3'd7
  } cmd_e;

  typedef enum logic [0:0] {
    REG_TRACKED  = 1'b0,
    REG_RESERVED = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EVAL,
    ST_RUN_RD,
    ST_RUN_STEP,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_REF_WR,
    ST_PAGE_RD,
    ST_PAGE_EXE
  } state_e;

  function automatic word_idx_t lowest_set(map_word_t v);
    word_idx_t r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) begin
        r = word_idx_t'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: sv/bitmap_page_allocator_refcount.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator with reference counts
// Used/free bitmap of 64-bit words, a 16-bit count per page, a next-fit hint
// and a free page count, driven by a small sequencer over a bitmap and a count memory.
// ----------------------------------------------------------------------------
//  Channel   | Signals                                   | Handshake
//  command   | cmd_i, phys_addr_i, run_count_i           | start & !busy
//  result    | result_addr_o, ok_o, ref_count_o,         | done_o, one cycle
//            | is_last_ref_o, free_pages_o               |
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i          | cfg_we_i
//
// A single page allocation reads and then evaluates each bitmap word it visits.
// A contiguous allocation walks one page per cycle, stopping to read each new
// bitmap word, then reads and writes each word of the run and writes the
// count of each page of the run to mark it.
// Other commands read the page's bitmap word and count, then execute; a
// rejected request is answered in the next cycle without going busy.
// After reset a clearing pass runs with busy high, zeroing every page count
// and marking every page used. Results cannot be stalled.
module bitmap_page_allocator_refcount (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  logic [2:0]   cmd_i,
  input  logic [47:0]  phys_addr_i,
  input  logic [12:0]  run_count_i,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [12:0]  cfg_wdata_i,
  output logic         done_o,
  output logic [23:0]  result_addr_o,
  output logic         ok_o,
  output logic [15:0]  ref_count_o,
  output logic         is_last_ref_o,
  output logic [12:0]  free_pages_o
);

  bpa_pkg::state_e state_q, state_d;

  bpa_pkg::page_t tracked_q, reserved_q;
  bpa_pkg::page_t hint_q, hint_d, free_q, free_d;
  bpa_pkg::page_t pg_q, pg_d, lo_q, lo_d, hi_q, hi_d;
  bpa_pkg::page_t want_q, want_d, len_q, len_d, start_q, start_d, endp_q, endp_d;
  bpa_pkg::word_idx_t w_q, w_d;
  logic phase2_q, phase2_d;
  logic [2:0] cmd_q, cmd_d;
  logic [11:0] clr_q;

  logic [23:0] res_q, res_d;
  logic ok_q, ok_d, done_q, done_d;
  bpa_pkg::ref_t refc_q, refc_d;

  bpa_pkg::map_word_t map_mem [bpa_pkg::WordCount];
  bpa_pkg::ref_t      ref_mem [bpa_pkg::PageCount];
  bpa_pkg::map_word_t map_rdata_q, map_wdata;
  bpa_pkg::ref_t      ref_rdata_q, ref_wdata;
  bpa_pkg::word_idx_t map_raddr, map_waddr;
  logic [11:0] ref_raddr, ref_waddr;
  logic map_we, ref_we;

  bpa_pkg::page_t lim;
  bpa_pkg::page_t hint_fix;
  bpa_pkg::map_word_t cand, run_mask;
  logic [6:0] w_next;
  logic word_end, addr_ok, cur_bit;
  bpa_pkg::page_t run_first;

  assign lim = (tracked_q > bpa_pkg::PageLimit) ? bpa_pkg::PageLimit : tracked_q;
  assign hint_fix = (hint_q < reserved_q || hint_q >= lim) ? reserved_q : hint_q;
  assign w_next = {1'b0, w_q} + 7'd1;
  assign word_end = {w_next, 6'd0} >= hi_q;
  assign addr_ok = (phys_addr_i[11:0] == 12'd0) && (phys_addr_i[47:25] == 23'd0) &&
                   (phys_addr_i[24:12] < lim);
  assign cur_bit = map_rdata_q[pg_q[5:0]];
  assign run_first = (len_q == 13'd0) ? pg_q : start_q;

  always_comb begin
    bpa_pkg::page_t p;
    for (int b = 0; b < 64; b++) begin
      p = {1'b0, w_q, 6'(b)};
      cand[b]     = !map_rdata_q[b] && (p >= lo_q) && (p < hi_q);
      run_mask[b] = (p >= start_q) && (p <= endp_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rdata_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
    ref_rdata_q <= ref_mem[ref_raddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpa_pkg::ST_CLEAR: begin
        if (clr_q == 12'hfff) begin
          state_d = bpa_pkg::ST_IDLE;
        end
      end
      bpa_pkg::ST_IDLE: begin
        if (start) begin
          unique case (bpa_pkg::cmd_e'(cmd_i))
            bpa_pkg::CMD_ALLOC: begin
              if (hint_fix < lim) begin
                state_d = bpa_pkg::ST_SCAN_RD;
              end
            end
            bpa_pkg::CMD_ALLOC_RUN: begin
              if (run_count_i != 13'd0 && run_count_i <= lim && reserved_q < lim) begin
                state_d = bpa_pkg::ST_RUN_RD;
              end
            end
            bpa_pkg::CMD_NONE: state_d = bpa_pkg::ST_IDLE;
            default: begin
              if (addr_ok) begin
                state_d = bpa_pkg::ST_PAGE_RD;
              end
            end
          endcase
        end
      end
      bpa_pkg::ST_SCAN_RD: state_d = bpa_pkg::ST_SCAN_EVAL;
      bpa_pkg::ST_SCAN_EVAL: begin
        if (cand != '0) begin
          state_d = bpa_pkg::ST_IDLE;
        end else if (word_end) begin
          state_d = (!phase2_q && hint_q > reserved_q) ? bpa_pkg::ST_SCAN_RD
                                                       : bpa_pkg::ST_IDLE;
        end else begin
          state_d = bpa_pkg::ST_SCAN_RD;
        end
      end
      bpa_pkg::ST_RUN_RD: state_d = bpa_pkg::ST_RUN_STEP;
      bpa_pkg::ST_RUN_STEP: begin
        if (pg_q >= lim) begin
          state_d = bpa_pkg::ST_IDLE;
        end else if (!cur_bit && (len_q + 13'd1 == want_q)) begin
          state_d = bpa_pkg::ST_MARK_RD;
        end else if (pg_q[5:0] == 6'd63) begin
          state_d = bpa_pkg::ST_RUN_RD;
        end
      end
      bpa_pkg::ST_MARK_RD: state_d = bpa_pkg::ST_MARK_WR;
      bpa_pkg::ST_MARK_WR: begin
        state_d = (w_q == endp_q[11:6]) ? bpa_pkg::ST_REF_WR : bpa_pkg::ST_MARK_RD;
      end
      bpa_pkg::ST_REF_WR: begin
        if (pg_q == endp_q) begin
          state_d = bpa_pkg::ST_IDLE;
        end
      end
      bpa_pkg::ST_PAGE_RD: state_d = bpa_pkg::ST_PAGE_EXE;
      bpa_pkg::ST_PAGE_EXE: state_d = bpa_pkg::ST_IDLE;
      default: state_d = bpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    bpa_pkg::page_t pf;
    bpa_pkg::ref_t r, nr;
    hint_d = hint_q;
    free_d = free_q;
    pg_d = pg_q;
    lo_d = lo_q;
    hi_d = hi_q;
    want_d = want_q;
    len_d = len_q;
    start_d = start_q;
    endp_d = endp_q;
    w_d = w_q;
    phase2_d = phase2_q;
    cmd_d = cmd_q;
    res_d = res_q;
    ok_d = ok_q;
    refc_d = refc_q;
    done_d = 1'b0;
    map_we = 1'b0;
    map_waddr = w_q;
    map_wdata = map_rdata_q;
    map_raddr = w_q;
    ref_we = 1'b0;
    ref_waddr = pg_q[11:0];
    ref_wdata = 16'd1;
    ref_raddr = pg_q[11:0];
    pf = {1'b0, w_q, bpa_pkg::lowest_set(cand)};
    r = ref_rdata_q;
    nr = r;

    unique case (state_q)
      bpa_pkg::ST_CLEAR: begin
        ref_we = 1'b1;
        ref_waddr = clr_q;
        ref_wdata = '0;
        map_we = (clr_q < 12'd64);
        map_waddr = clr_q[5:0];
        map_wdata = '1;
      end
      bpa_pkg::ST_IDLE: begin
        if (start) begin
          cmd_d = cmd_i;
          res_d = '0;
          ok_d = 1'b0;
          refc_d = '0;
          unique case (bpa_pkg::cmd_e'(cmd_i))
            bpa_pkg::CMD_ALLOC: begin
              hint_d = hint_fix;
              lo_d = hint_fix;
              hi_d = lim;
              w_d = hint_fix[11:6];
              phase2_d = 1'b0;
              done_d = (hint_fix >= lim);
            end
            bpa_pkg::CMD_ALLOC_RUN: begin
              want_d = run_count_i;
              pg_d = reserved_q;
              len_d = '0;
              done_d = !(run_count_i != 13'd0 && run_count_i <= lim && reserved_q < lim);
            end
            bpa_pkg::CMD_NONE: done_d = 1'b1;
            default: begin
              pg_d = phys_addr_i[24:12];
              done_d = !addr_ok;
            end
          endcase
        end
      end
      bpa_pkg::ST_SCAN_RD: begin
        map_raddr = w_q;
      end
      bpa_pkg::ST_SCAN_EVAL: begin
        if (cand != '0) begin
          map_we = 1'b1;
          map_wdata = map_rdata_q | (64'd1 << pf[5:0]);
          ref_we = 1'b1;
          ref_waddr = pf[11:0];
          ref_wdata = 16'd1;
          hint_d = pf + 13'd1;
          free_d = (free_q != 13'd0) ? free_q - 13'd1 : free_q;
          res_d = {pf[11:0], 12'd0};
          ok_d = 1'b1;
          refc_d = 16'd1;
          done_d = 1'b1;
        end else if (word_end) begin
          if (!phase2_q && hint_q > reserved_q) begin
            phase2_d = 1'b1;
            lo_d = reserved_q;
            hi_d = hint_q;
            w_d = reserved_q[11:6];
          end else begin
            done_d = 1'b1;
          end
        end else begin
          w_d = w_next[5:0];
        end
      end
      bpa_pkg::ST_RUN_RD: begin
        map_raddr = pg_q[11:6];
      end
      bpa_pkg::ST_RUN_STEP: begin
        map_raddr = pg_q[11:6];
        if (pg_q >= lim) begin
          done_d = 1'b1;
        end else begin
          pg_d = pg_q + 13'd1;
          if (cur_bit) begin
            len_d = '0;
          end else begin
            start_d = run_first;
            len_d = len_q + 13'd1;
            if (len_q + 13'd1 == want_q) begin
              endp_d = run_first + want_q - 13'd1;
              w_d = run_first[11:6];
            end
          end
        end
      end
      bpa_pkg::ST_MARK_RD: begin
        map_raddr = w_q;
      end
      bpa_pkg::ST_MARK_WR: begin
        map_we = 1'b1;
        map_wdata = map_rdata_q | run_mask;
        if (w_q == endp_q[11:6]) begin
          pg_d = start_q;
        end else begin
          w_d = w_next[5:0];
        end
      end
      bpa_pkg::ST_REF_WR: begin
        ref_we = 1'b1;
        ref_wdata = 16'd1;
        if (pg_q == endp_q) begin
          hint_d = endp_q + 13'd1;
          free_d = (free_q >= want_q) ? free_q - want_q : '0;
          res_d = {start_q[11:0], 12'd0};
          ok_d = 1'b1;
          refc_d = 16'd1;
          done_d = 1'b1;
        end else begin
          pg_d = pg_q + 13'd1;
        end
      end
      bpa_pkg::ST_PAGE_RD: begin
        map_raddr = pg_q[11:6];
        ref_raddr = pg_q[11:0];
      end
      bpa_pkg::ST_PAGE_EXE: begin
        map_waddr = pg_q[11:6];
        done_d = 1'b1;
        unique case (bpa_pkg::cmd_e'(cmd_q))
          bpa_pkg::CMD_FREE: begin
            if (r != 16'd0) begin
              nr = r - 16'd1;
              ok_d = 1'b1;
              ref_we = 1'b1;
              ref_wdata = nr;
              if (nr == 16'd0) begin
                if (cur_bit) begin
                  map_we = 1'b1;
                  map_wdata = map_rdata_q & ~(64'd1 << pg_q[5:0]);
                  free_d = (free_q != bpa_pkg::CountMax) ? free_q + 13'd1 : free_q;
                end
                hint_d = (pg_q < hint_q) ? pg_q : hint_q;
              end
            end
          end
          bpa_pkg::CMD_SHARE: begin
            if (r != 16'd0 && r != bpa_pkg::RefMax) begin
              nr = r + 16'd1;
              ok_d = 1'b1;
              ref_we = 1'b1;
              ref_wdata = nr;
            end
          end
          bpa_pkg::CMD_MARK_FREE: begin
            ok_d = 1'b1;
            nr = '0;
            ref_we = 1'b1;
            ref_wdata = nr;
            if (cur_bit) begin
              map_we = 1'b1;
              map_wdata = map_rdata_q & ~(64'd1 << pg_q[5:0]);
              free_d = (free_q != bpa_pkg::CountMax) ? free_q + 13'd1 : free_q;
            end
          end
          bpa_pkg::CMD_MARK_USED: begin
            ok_d = 1'b1;
            nr = (r == 16'd0) ? 16'd1 : r;
            ref_we = 1'b1;
            ref_wdata = nr;
            if (!cur_bit) begin
              map_we = 1'b1;
              map_wdata = map_rdata_q | (64'd1 << pg_q[5:0]);
              free_d = (free_q != 13'd0) ? free_q - 13'd1 : free_q;
            end
          end
          default: begin
            ok_d = 1'b1;
          end
        endcase
        refc_d = nr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpa_pkg::ST_CLEAR;
      clr_q <= '0;
      tracked_q <= '0;
      reserved_q <= bpa_pkg::ReservedReset;
      hint_q <= bpa_pkg::HintReset;
      free_q <= '0;
      done_q <= 1'b0;
      res_q <= '0;
      ok_q <= 1'b0;
      refc_q <= '0;
      phase2_q <= 1'b0;
      cmd_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == bpa_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 12'd1;
      end
      if (cfg_we_i) begin
        unique case (bpa_pkg::reg_e'(cfg_idx_i))
          bpa_pkg::REG_TRACKED:  tracked_q <= cfg_wdata_i;
          bpa_pkg::REG_RESERVED: reserved_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      hint_q <= hint_d;
      free_q <= free_d;
      done_q <= done_d;
      res_q <= res_d;
      ok_q <= ok_d;
      refc_q <= refc_d;
      phase2_q <= phase2_d;
      cmd_q <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pg_q <= pg_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    want_q <= want_d;
    len_q <= len_d;
    start_q <= start_d;
    endp_q <= endp_d;
    w_q <= w_d;
  end

  assign busy = (state_q != bpa_pkg::ST_IDLE);
  assign done_o = done_q;
  assign result_addr_o = res_q;
  assign ok_o = ok_q;
  assign ref_count_o = refc_q;
  assign is_last_ref_o = (refc_q == 16'd1);
  assign free_pages_o = free_q;

endmodule

// File: sv/bpa_checker.sv
// ----------------------------------------------------------------------------
// Page allocator port checker
// Checks on the result port of the page allocator over time.
// ----------------------------------------------------------------------------
module bpa_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         start,
  input logic         busy,
  input logic         done_o,
  input logic [23:0]  result_addr_o,
  input logic         ok_o,
  input logic [15:0]  ref_count_o,
  input logic [12:0]  free_pages_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("Result shown while still busy.");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o)) else $error("Request neither worked on nor answered.");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (result_addr_o == 24'd0))
    else $error("Failed request returned an address.");

  a_alloc_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_addr_o != 24'd0) |-> (ok_o && ref_count_o == 16'd1))
    else $error("Allocated page does not hold a single reference.");

  a_free_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(free_pages_o)) else $error("Free count moved without a result.");

endmodule

bind bitmap_page_allocator_refcount bpa_checker u_bpa_checker (.*);
